// ----- hdl/ackst_pkg.sv -----
package ackst_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int TAB_LEN             = 24;

  localparam int POS_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int LEN_W      = 12;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int CW = 34;
  localparam int PW = 48;
  localparam int VW = 52;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERVO_OFFSET = 8'd0,
    REG_SERVO_GAIN   = 8'd1,
    REG_WHEELBASE    = 8'd2,
    REG_TRACK        = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic vld;
    logic zero;
  } ctl_t;

  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  function automatic longint half_pi_fix(input int frac);
    return (HALF_PI_Q30 + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
  endfunction

endpackage

// ----- hdl/ackst_div.sv -----
module ackst_div #(
  parameter int FRAC = ackst_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic [ackst_pkg::POS_W-1:0]         pos_i,
  input  logic [ackst_pkg::POS_W-1:0]         offset_i,
  input  logic signed [ackst_pkg::GAIN_W-1:0] gain_i,
  input  logic                                wb_zero_i,
  output ackst_pkg::ctl_t                     ctl_o,
  output logic signed [ackst_pkg::CW-1:0]     z_o
);

  localparam int QB   = FRAC + 1;
  localparam int DW   = FRAC + 14;
  localparam int CMPW = FRAC + 18;
  localparam logic [QB-1:0] PMAG = QB'(ackst_pkg::half_pi_fix(FRAC));

  logic signed [16:0] diff;
  logic [16:0]        dabs;
  logic [16:0]        gext;
  logic [16:0]        gabs;
  logic [DW-1:0]      an;
  logic [DW-1:0]      dvd;
  logic [16:0]        dv;
  logic               ovf;

  always_comb begin
    diff = $signed({1'b0, pos_i}) - $signed({1'b0, offset_i});
    dabs = diff[16] ? 17'(-diff) : 17'(diff);
    gext = {gain_i[15], gain_i};
    gabs = gain_i[15] ? 17'(-gext) : gext;
    an   = DW'(dabs[15:0]) << (FRAC - 4);
    dvd  = (an << 1) + DW'(gabs[15:0]);
    dv   = {gabs[15:0], 1'b0};
    ovf  = CMPW'(dvd) >= (CMPW'(dv) << QB);
  end

  ackst_pkg::ctl_t ctl_q [QB+1];
  logic [DW-1:0]   rem_q [QB+1];
  logic [QB-1:0]   quo_q [QB+1];
  logic [16:0]     dv_q  [QB+1];
  logic            ovf_q [QB+1];
  logic            neg_q [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else if (en_i) begin
      ctl_q[0].vld  <= vld_i;
      ctl_q[0].zero <= (gain_i == '0) || wb_zero_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= dvd;
      quo_q[0] <= '0;
      dv_q[0]  <= dv;
      ovf_q[0] <= ovf;
      neg_q[0] <= diff[16] ^ gain_i[15];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_bit
    localparam int K = QB - 1 - j;
    logic [CMPW-1:0] sh;
    logic            ge;
    assign sh = CMPW'(dv_q[j]) << K;
    assign ge = CMPW'(rem_q[j]) >= sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[j+1] <= '0;
      end else if (en_i) begin
        ctl_q[j+1] <= ctl_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge ? DW'(CMPW'(rem_q[j]) - sh) : rem_q[j];
        quo_q[j+1] <= quo_q[j] | (ge ? (QB'(1) << K) : '0);
        dv_q[j+1]  <= dv_q[j];
        ovf_q[j+1] <= ovf_q[j];
        neg_q[j+1] <= neg_q[j];
      end
    end
  end

  logic [QB-1:0]      mag;
  logic signed [QB:0] ang;

  always_comb begin
    mag = (ovf_q[QB] || (quo_q[QB] > PMAG)) ? PMAG : quo_q[QB];
    ang = neg_q[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  ackst_pkg::ctl_t                 ctl_out_q;
  logic signed [ackst_pkg::CW-1:0] z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_out_q <= '0;
    end else if (en_i) begin
      ctl_out_q.vld  <= ctl_q[QB].vld;
      ctl_out_q.zero <= ctl_q[QB].zero || (mag == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q <= ackst_pkg::CW'(ang) <<< (30 - FRAC);
    end
  end

  assign ctl_o = ctl_out_q;
  assign z_o   = z_q;

endmodule

// ----- hdl/ackst_rot.sv -----
module ackst_rot #(
  parameter int STEPS = ackst_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  ackst_pkg::ctl_t                 ctl_i,
  input  logic signed [ackst_pkg::CW-1:0] z_i,
  output ackst_pkg::ctl_t                 ctl_o,
  output logic signed [ackst_pkg::CW-1:0] cos_o,
  output logic signed [ackst_pkg::CW-1:0] sin_o
);

  localparam int CW = ackst_pkg::CW;

  ackst_pkg::ctl_t      ctl_s [STEPS+1];
  logic signed [CW-1:0] x_s   [STEPS+1];
  logic signed [CW-1:0] y_s   [STEPS+1];
  logic signed [CW-1:0] z_s   [STEPS+1];

  assign ctl_s[0] = ctl_i;
  assign x_s[0]   = CW'(64'sd1 <<< 30);
  assign y_s[0]   = '0;
  assign z_s[0]   = z_i;

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] t;
    assign dx = y_s[i] >>> i;
    assign dy = x_s[i] >>> i;
    assign t  = $signed(CW'(ackst_pkg::ATAN_TAB[i]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_s[i+1] <= '0;
      end else if (en_i) begin
        ctl_s[i+1] <= ctl_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_s[i][CW-1]) begin
          x_s[i+1] <= x_s[i] - dx;
          y_s[i+1] <= y_s[i] + dy;
          z_s[i+1] <= z_s[i] - t;
        end else begin
          x_s[i+1] <= x_s[i] + dx;
          y_s[i+1] <= y_s[i] - dy;
          z_s[i+1] <= z_s[i] + t;
        end
      end
    end
  end

  assign ctl_o = ctl_s[STEPS];
  assign cos_o = x_s[STEPS];
  assign sin_o = y_s[STEPS];

endmodule

// ----- hdl/ackst_vec.sv -----
module ackst_vec #(
  parameter int STEPS = ackst_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  ackst_pkg::ctl_t                 ctl_i,
  input  logic signed [ackst_pkg::VW-1:0] x_i,
  input  logic signed [ackst_pkg::VW-1:0] y_i,
  output ackst_pkg::ctl_t                 ctl_o,
  output logic signed [ackst_pkg::CW-1:0] z_o
);

  localparam int VW = ackst_pkg::VW;
  localparam int CW = ackst_pkg::CW;

  ackst_pkg::ctl_t      ctl_s [STEPS+1];
  logic signed [VW-1:0] x_s   [STEPS+1];
  logic signed [VW-1:0] y_s   [STEPS+1];
  logic signed [CW-1:0] z_s   [STEPS+1];

  assign ctl_s[0] = ctl_i;
  assign x_s[0]   = x_i;
  assign y_s[0]   = y_i;
  assign z_s[0]   = '0;

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    logic signed [CW-1:0] t;
    assign dx = y_s[i] >>> i;
    assign dy = x_s[i] >>> i;
    assign t  = $signed(CW'(ackst_pkg::ATAN_TAB[i]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_s[i+1] <= '0;
      end else if (en_i) begin
        ctl_s[i+1] <= ctl_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_s[i][VW-1]) begin
          x_s[i+1] <= x_s[i] - dx;
          y_s[i+1] <= y_s[i] + dy;
          z_s[i+1] <= z_s[i] - t;
        end else begin
          x_s[i+1] <= x_s[i] + dx;
          y_s[i+1] <= y_s[i] - dy;
          z_s[i+1] <= z_s[i] + t;
        end
      end
    end
  end

  assign ctl_o = ctl_s[STEPS];
  assign z_o   = z_s[STEPS];

endmodule

// ----- hdl/ackermann_steering_angles_top.sv -----
// Channel   Direction  Handshake                        Payload
// s_axis    in         s_axis_tvalid_i/s_axis_tready_o  tdata[15:0] servo_cmd
// m_axis    out        m_axis_tvalid_o/m_axis_tready_i  tdata: left, right, left_mirror,
//                                                       right_mirror angles
// cfg       in         cfg_valid_i/cfg_ready_o          cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the output is not stalled.
// The datapath runs through the one-bit-per-stage divider and the unrolled CORDIC pipelines.
// Reset clears the valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline; s_axis_tready_o follows the output slot.
module ackermann_steering_angles_top #(
  parameter int ANGLE_FRAC_BITS = ackst_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = ackst_pkg::CORDIC_STEPS_DEF,
  parameter int OW              = ANGLE_FRAC_BITS + 2,
  parameter int OUT_W           = ((4 * OW + 7) / 8) * 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [ackst_pkg::POS_W-1:0]          s_axis_tdata_i,   // servo_cmd
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [OUT_W-1:0]                     m_axis_tdata_o,   // left_angle, right_angle,
                                                                 // left_mirror_angle,
                                                                 // right_mirror_angle
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ackst_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ackst_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int CW = ackst_pkg::CW;
  localparam int PW = ackst_pkg::PW;
  localparam int VW = ackst_pkg::VW;
  localparam int SH = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [CW-1:0] PLIM = CW'(ackst_pkg::half_pi_fix(ANGLE_FRAC_BITS));

  logic [15:0]        offset_q;
  logic signed [15:0] gain_q;
  logic [11:0]        wb_q;
  logic [11:0]        tr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 16'd32768;
      gain_q   <= -16'sd4970;
      wb_q     <= 12'd325;
      tr_q     <= 12'd230;
    end else if (cfg_valid_i) begin
      case (ackst_pkg::cfg_reg_e'(cfg_index_i))
        ackst_pkg::REG_SERVO_OFFSET: offset_q <= cfg_data_i;
        ackst_pkg::REG_SERVO_GAIN:   gain_q   <= $signed(cfg_data_i);
        ackst_pkg::REG_WHEELBASE:    wb_q     <= cfg_data_i[11:0];
        ackst_pkg::REG_TRACK:        tr_q     <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  logic out_vld_q;
  logic en;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  ackst_pkg::ctl_t      div_ctl;
  logic signed [CW-1:0] div_z;

  ackst_div #(.FRAC(ANGLE_FRAC_BITS)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (s_axis_tvalid_i),
    .pos_i     (s_axis_tdata_i),
    .offset_i  (offset_q),
    .gain_i    (gain_q),
    .wb_zero_i (wb_q == '0),
    .ctl_o     (div_ctl),
    .z_o       (div_z)
  );

  ackst_pkg::ctl_t      rot_ctl;
  logic signed [CW-1:0] rot_cos;
  logic signed [CW-1:0] rot_sin;

  ackst_rot #(.STEPS(CORDIC_STEPS)) u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (div_ctl),
    .z_i    (div_z),
    .ctl_o  (rot_ctl),
    .cos_o  (rot_cos),
    .sin_o  (rot_sin)
  );

  ackst_pkg::ctl_t      mul_ctl_q;
  logic signed [PW-1:0] py_q;
  logic signed [PW-1:0] pt_q;
  logic signed [PW-1:0] pc_q;
  logic signed [PW-1:0] py_d;
  logic signed [PW-1:0] pt_d;
  logic signed [PW-1:0] pc_d;

  always_comb begin
    py_d = $signed({2'b00, wb_q, 1'b0}) * rot_sin;
    pt_d = $signed({3'b000, tr_q}) * rot_sin;
    pc_d = $signed({2'b00, wb_q, 1'b0}) * rot_cos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_ctl_q <= '0;
    end else if (en) begin
      mul_ctl_q <= rot_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      py_q <= py_d;
      pt_q <= pt_d;
      pc_q <= pc_d;
    end
  end

  ackst_pkg::ctl_t      sum_ctl_q;
  logic signed [VW-1:0] xl_d;
  logic signed [VW-1:0] xr_d;
  logic signed [VW-1:0] yy;
  logic signed [VW-1:0] xl_q;
  logic signed [VW-1:0] yl_q;
  logic signed [VW-1:0] xr_q;
  logic signed [VW-1:0] yr_q;

  always_comb begin
    yy   = VW'(py_q);
    xl_d = VW'(pt_q) - VW'(pc_q);
    xr_d = -VW'(pt_q) - VW'(pc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_ctl_q <= '0;
    end else if (en) begin
      sum_ctl_q <= mul_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xl_q <= xl_d[VW-1] ? -xl_d : xl_d;
      yl_q <= xl_d[VW-1] ? -yy : yy;
      xr_q <= xr_d[VW-1] ? -xr_d : xr_d;
      yr_q <= xr_d[VW-1] ? -yy : yy;
    end
  end

  ackst_pkg::ctl_t      vec_ctl;
  logic signed [CW-1:0] zl;
  logic signed [CW-1:0] zr;

  ackst_vec #(.STEPS(CORDIC_STEPS)) u_vec_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (sum_ctl_q),
    .x_i    (xl_q),
    .y_i    (yl_q),
    .ctl_o  (vec_ctl),
    .z_o    (zl)
  );

  ackst_vec #(.STEPS(CORDIC_STEPS)) u_vec_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (sum_ctl_q),
    .x_i    (xr_q),
    .y_i    (yr_q),
    .ctl_o  (),
    .z_o    (zr)
  );

  logic signed [CW-1:0] rl;
  logic signed [CW-1:0] rr;
  logic signed [CW-1:0] cl;
  logic signed [CW-1:0] cr;
  logic signed [OW-1:0] left;
  logic signed [OW-1:0] right;

  always_comb begin
    rl = (-zl + CW'(64'sd1 <<< (SH - 1))) >>> SH;
    rr = (-zr + CW'(64'sd1 <<< (SH - 1))) >>> SH;
    cl = (rl > PLIM) ? PLIM : ((rl < -PLIM) ? -PLIM : rl);
    cr = (rr > PLIM) ? PLIM : ((rr < -PLIM) ? -PLIM : rr);
    left  = vec_ctl.zero ? '0 : OW'(cl);
    right = vec_ctl.zero ? '0 : OW'(cr);
  end

  logic [OUT_W-1:0] tdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vec_ctl.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= OUT_W'({OW'(-right), OW'(-left), right, left});
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = tdata_q;

endmodule
